### sv/art_pkg.sv
// Shared types, constants and tables of the arc ring tessellator.
package art_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int COORD_BITS   = 16;
	localparam int PHASE_BITS   = 32;
	localparam int FRAC_BITS    = PHASE_BITS - ANGLE_BITS;
	localparam int CORDIC_ITERS = 24;
	localparam int XY_W         = 34;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic [PHASE_BITS-1:0] EIGHTH_PHASE = 32'h2000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_INNER_RAD  = 3'd2,
		REG_THICKNESS  = 3'd3,
		REG_SEG_COUNT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] start_angle;
		logic signed [ANGLE_BITS-1:0] end_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_a_x;
		logic signed [COORD_BITS-1:0] vertex_a_y;
		logic signed [COORD_BITS-1:0] vertex_b_x;
		logic signed [COORD_BITS-1:0] vertex_b_y;
		logic signed [COORD_BITS-1:0] vertex_c_x;
		logic signed [COORD_BITS-1:0] vertex_c_y;
		logic                         last_triangle;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       mul;
		logic       div_step;
		logic       phase_load;
		logic       cordic_step;
		logic       rot;
		logic       pt_mul;
		logic       pt_wr;
		logic       emit;
		logic       emit_half;
		logic       emit_last;
		logic       shift;
		logic [4:0] iter;
		logic [1:0] pt_sel;
		logic       second;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [PHASE_BITS-1:0] atan_phase(input logic [4:0] i);
		logic [PHASE_BITS-1:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### sv/art_dp.sv
// Datapath: configuration, edge divider, CORDIC, point scaling and output register.
module art_dp #(
	parameter int MAX_SEGMENTS = 32,
	parameter int N_W          = 6,
	parameter int DIV_STEPS    = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [art_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [art_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  art_pkg::in_item_t                   in_data,
	input  art_pkg::cmd_t                       cmd,
	input  logic [N_W-1:0]                      k,
	output logic [N_W-1:0]                      seg_n,
	output art_pkg::sts_t                       sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output art_pkg::out_item_t                  out_data
);

	localparam int PROD_W = N_W + art_pkg::ANGLE_BITS;
	localparam int PW     = art_pkg::PHASE_BITS;
	localparam int XW     = art_pkg::XY_W;
	localparam int CW     = art_pkg::COORD_BITS;

	logic signed [15:0] cx_q, cy_q;
	logic [13:0]        ri_q, th_q;
	logic [5:0]         sc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ri_q <= '0;
			th_q <= '0;
			sc_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_idx)
				art_pkg::REG_CENTER_X:  cx_q <= cfg_data;
				art_pkg::REG_CENTER_Y:  cy_q <= cfg_data;
				art_pkg::REG_INNER_RAD: ri_q <= cfg_data[13:0];
				art_pkg::REG_THICKNESS: th_q <= cfg_data[13:0];
				art_pkg::REG_SEG_COUNT: sc_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sc_q == 6'd0)
			seg_n = N_W'(1);
		else if (sc_q > 6'(MAX_SEGMENTS))
			seg_n = N_W'(MAX_SEGMENTS);
		else
			seg_n = N_W'(sc_q);
	end

	// Arc request.
	logic signed [art_pkg::ANGLE_BITS-1:0] a0_q;
	logic                                  neg_q;
	logic [art_pkg::ANGLE_BITS-1:0]        absd_q;
	logic signed [art_pkg::ANGLE_BITS:0]   diff;

	assign diff = {in_data.end_angle[art_pkg::ANGLE_BITS-1], in_data.end_angle}
		- {in_data.start_angle[art_pkg::ANGLE_BITS-1], in_data.start_angle};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a0_q   <= in_data.start_angle;
			neg_q  <= diff[art_pkg::ANGLE_BITS];
			absd_q <= diff[art_pkg::ANGLE_BITS] ? art_pkg::ANGLE_BITS'(-diff)
				: diff[art_pkg::ANGLE_BITS-1:0];
		end
	end

	// Restoring divider, one quotient bit a cycle.
	logic [DIV_STEPS-1:0] dvd_q;
	logic [N_W-1:0]       rem_q;
	logic [PROD_W-1:0]    prod;
	logic [N_W:0]         trial;
	logic                 ge;

	assign prod  = PROD_W'(k) * PROD_W'(absd_q);
	assign trial = {rem_q, dvd_q[DIV_STEPS-1]};
	assign ge    = trial >= {1'b0, seg_n};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dvd_q <= {prod, {art_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? N_W'(trial - {1'b0, seg_n}) : trial[N_W-1:0];
			dvd_q <= {dvd_q[DIV_STEPS-2:0], ge};
		end
	end

	// Phase and CORDIC.
	logic [PW-1:0]        q32, off, ph, pe;
	logic [1:0]           quad_q;
	logic signed [PW-1:0] z_q, at;
	logic signed [XW-1:0] x_q, y_q, dx, dy;

	assign q32 = dvd_q[PW-1:0];
	assign off = neg_q ? (~q32 + 1'b1) : q32;
	assign ph  = {a0_q, {art_pkg::FRAC_BITS{1'b0}}} + off;
	assign pe  = ph + art_pkg::EIGHTH_PHASE;
	assign dx  = y_q >>> cmd.iter;
	assign dy  = x_q >>> cmd.iter;
	assign at  = $signed(art_pkg::atan_phase(cmd.iter));

	always_ff @(posedge clk) begin
		if (cmd.phase_load) begin
			quad_q <= pe[PW-1:PW-2];
			z_q    <= $signed({2'b00, pe[PW-3:0]}) - $signed(art_pkg::EIGHTH_PHASE);
			x_q    <= art_pkg::CORDIC_GAIN;
			y_q    <= '0;
		end else if (cmd.cordic_step) begin
			if (!z_q[PW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	logic signed [PW-1:0] cos_q, sin_q, xs, ys;
	assign xs = x_q[PW-1:0];
	assign ys = y_q[PW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rot) begin
			case (quad_q)
				2'd0: begin cos_q <= xs;  sin_q <= ys;  end
				2'd1: begin cos_q <= -ys; sin_q <= xs;  end
				2'd2: begin cos_q <= -xs; sin_q <= -ys; end
				default: begin cos_q <= ys; sin_q <= -xs; end
			endcase
		end
	end

	// Point scaling: one radius by cos or sin, then round, offset and clamp.
	logic [14:0]             ro, rsel;
	logic signed [15:0]      rs;
	logic signed [PW+15:0]   pm_q, rnd;
	logic signed [17:0]      v;
	logic signed [19:0]      sum;
	logic signed [CW-1:0]    sat;
	logic signed [CW-1:0]    edge_q [8];

	assign ro   = {1'b0, ri_q} + {1'b0, th_q};
	assign rsel = cmd.pt_sel[1] ? ro : {1'b0, ri_q};
	assign rs   = $signed({1'b0, rsel});
	assign rnd  = pm_q + (PW+16)'(art_pkg::EIGHTH_PHASE);
	assign v    = rnd[47:30];
	assign sum  = cmd.pt_sel[0] ? (20'(cy_q) - 20'(v)) : (20'(cx_q) + 20'(v));

	always_comb begin
		if (sum > 20'sd32767)
			sat = 16'sh7FFF;
		else if (sum < -20'sd32768)
			sat = 16'sh8000;
		else
			sat = sum[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.pt_mul)
			pm_q <= rs * (cmd.pt_sel[0] ? sin_q : cos_q);
		if (cmd.pt_wr)
			edge_q[{cmd.second, cmd.pt_sel}] <= sat;
		else if (cmd.shift) begin
			edge_q[0] <= edge_q[4];
			edge_q[1] <= edge_q[5];
			edge_q[2] <= edge_q[6];
			edge_q[3] <= edge_q[7];
		end
	end

	// Output register.
	logic              out_valid_q;
	art_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.vertex_a_x    <= cmd.emit_half ? edge_q[4] : edge_q[0];
			out_q.vertex_a_y    <= cmd.emit_half ? edge_q[5] : edge_q[1];
			out_q.vertex_b_x    <= edge_q[2];
			out_q.vertex_b_y    <= edge_q[3];
			out_q.vertex_c_x    <= cmd.emit_half ? edge_q[6] : edge_q[4];
			out_q.vertex_c_y    <= cmd.emit_half ? edge_q[7] : edge_q[5];
			out_q.last_triangle <= cmd.emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

### sv/art_ctrl.sv
// Controller: sequences division, CORDIC, point scaling and triangle output per edge.
module art_ctrl #(
	parameter int N_W       = 6,
	parameter int DIV_STEPS = 38,
	parameter int CNT_W     = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [N_W-1:0] seg_n,
	input  art_pkg::sts_t  sts,
	output art_pkg::cmd_t  cmd,
	output logic [N_W-1:0] k
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_DIV, S_PHASE, S_CORDIC, S_ROT,
		S_PMUL, S_PWR, S_TRI0, S_TRI1, S_SHIFT
	} state_t;

	state_t         state_q;
	logic [N_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]     sel_q;
	logic           last_edge;

	assign last_edge = k_q == seg_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			sel_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= S_PHASE;
				end
				S_PHASE: begin
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(art_pkg::CORDIC_ITERS - 1))
						state_q <= S_ROT;
				end
				S_ROT: begin
					sel_q   <= '0;
					state_q <= S_PMUL;
				end
				S_PMUL: state_q <= S_PWR;
				S_PWR: begin
					sel_q <= sel_q + 1'b1;
					if (sel_q != 2'd3)
						state_q <= S_PMUL;
					else if (k_q == '0) begin
						k_q     <= N_W'(1);
						state_q <= S_MUL;
					end else
						state_q <= S_TRI0;
				end
				S_TRI0: if (sts.out_free) state_q <= S_TRI1;
				S_TRI1: if (sts.out_free) state_q <= S_SHIFT;
				S_SHIFT: begin
					if (last_edge)
						state_q <= S_IDLE;
					else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.load        = state_q == S_IDLE && in_valid;
		cmd.mul         = state_q == S_MUL;
		cmd.div_step    = state_q == S_DIV;
		cmd.phase_load  = state_q == S_PHASE;
		cmd.cordic_step = state_q == S_CORDIC;
		cmd.rot         = state_q == S_ROT;
		cmd.pt_mul      = state_q == S_PMUL;
		cmd.pt_wr       = state_q == S_PWR;
		cmd.emit        = (state_q == S_TRI0 || state_q == S_TRI1) && sts.out_free;
		cmd.emit_half   = state_q == S_TRI1;
		cmd.emit_last   = state_q == S_TRI1 && last_edge;
		cmd.shift       = state_q == S_SHIFT;
		cmd.iter        = cnt_q[4:0];
		cmd.pt_sel      = sel_q;
		cmd.second      = k_q != '0;
	end

	assign in_ready = state_q == S_IDLE;
	assign k        = k_q;

endmodule

### sv/arc_ring_tessellator_top.sv
// Top level of the arc ring tessellator: controller, datapath and checks.
//
// An arc request (start and end binary angle) enters on the in channel as one
// valid/ready transaction. The ring sector between inner_radius and
// inner_radius + ring_thickness around the configured centre is cut into
// segment_count equal angular segments, and two triangles per segment leave on
// the out channel, one transaction each, the final one flagged last_triangle.
// Each of the n+1 segment edges costs one multiply, a one-bit-a-cycle
// restoring divide over DIV_STEPS dividend bits (38 at the default settings),
// a 24-iteration CORDIC and four shared-multiplier point evaluations, each a
// multiply then a clamped write; each segment then issues its triangle pair
// and shifts the edge registers. The divider and CORDIC loop take most of an
// arc's time. One arc is worked at a time; in_ready is high only between arcs.
// A stalled receiver holds the block at the next triangle; the finished
// triangle waits in the output register. Reset clears the controller, the
// output valid and the configuration (segment_count returns to 32). The
// configuration port takes one register write per cycle; the user must write
// it only when the block is idle, which the block itself does not enforce.
module arc_ring_tessellator_top #(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  art_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output art_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [art_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Segment count width, and the dividend width of the edge division:
	// the product k*|sweep| followed by the fractional phase bits.
	localparam int N_W       = $clog2(MAX_SEGMENTS + 1);
	localparam int DIV_STEPS = N_W + art_pkg::ANGLE_BITS + art_pkg::FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	art_pkg::cmd_t  cmd;
	art_pkg::sts_t  sts;
	logic [N_W-1:0] seg_n;
	logic [N_W-1:0] k;

	art_ctrl #(
		.N_W       (N_W),
		.DIV_STEPS (DIV_STEPS),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.seg_n    (seg_n),
		.sts      (sts),
		.cmd      (cmd),
		.k        (k)
	);

	art_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.N_W          (N_W),
		.DIV_STEPS    (DIV_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.k         (k),
		.seg_n     (seg_n),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An accepted arc keeps the input closed until its triangles are issued.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// The effective segment count always lies within the supported range.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_n >= N_W'(1) && seg_n <= N_W'(MAX_SEGMENTS))
		else $error("segment count out of range");

	// A triangle is never loaded over one that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid || out_ready)
		else $error("output register overwritten");

endmodule
